// ===== design/fct_pkg.sv =====
// shared types and constants for the frustum cull test
// no dependencies
package fct_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [1:0] {
        CMD_POINT  = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_QUAD   = 2'd2,
        CMD_BOX    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [23:0] center_x;
        logic [23:0] center_y;
        logic [23:0] center_z;
        logic [22:0] extent_x;
        logic [22:0] extent_y;
        logic [22:0] extent_z;
        logic [22:0] radius;
        logic [47:0] axis_first;
        logic [47:0] axis_second;
        logic [47:0] axis_third;
    } item_t;

    typedef struct packed {
        logic  vld;
        logic  vis;
        item_t item;
    } cell_bus_t;

endpackage

// ===== design/fct_if.sv =====
// valid/ready channel interfaces for primitives and results
// depends on nothing
interface fct_prim_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [23:0] center_x;
    logic [23:0] center_y;
    logic [23:0] center_z;
    logic [22:0] extent_x;
    logic [22:0] extent_y;
    logic [22:0] extent_z;
    logic [22:0] radius;
    logic [47:0] axis_first;
    logic [47:0] axis_second;
    logic [47:0] axis_third;

    modport source (output valid, command, center_x, center_y, center_z, extent_x,
                    extent_y, extent_z, radius, axis_first, axis_second, axis_third,
                    input ready);
    modport sink (input valid, command, center_x, center_y, center_z, extent_x,
                  extent_y, extent_z, radius, axis_first, axis_second, axis_third,
                  output ready);
endinterface

interface fct_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

// ===== design/fct_apb_regs.sv =====
// apb register file holding the six frustum planes
// depends on fct_pkg
module fct_apb_regs (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [fct_pkg::CFG_ADDR_W-1:0]              paddr,
    input  logic [fct_pkg::CFG_DATA_W-1:0]              pwdata,
    output logic [fct_pkg::CFG_DATA_W-1:0]              prdata,
    output logic                                        pready,
    output logic [fct_pkg::PLANE_COUNT-1:0][63:0]       planes
);
    import fct_pkg::*;

    logic [PLANE_COUNT-1:0][63:0] plane_reg;
    logic [2:0] idx;

    assign idx    = paddr[5:3];
    assign pready = 1'b1;
    assign planes = plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (psel && penable && pwrite && (int'(idx) < PLANE_COUNT))
        begin
            plane_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (int'(idx) < PLANE_COUNT)
        begin
            prdata = plane_reg[idx];
        end
    end
endmodule

// ===== design/fct_cell.sv =====
// one plane cell: three-stage test of a primitive against one plane
// depends on fct_pkg
module fct_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [63:0]        plane,
    input  fct_pkg::cell_bus_t bus_in,
    output fct_pkg::cell_bus_t bus_out
);
    import fct_pkg::*;

    logic signed [11:0] a, b, c;
    logic signed [27:0] d;
    logic signed [23:0] cx, cy, cz;
    logic signed [23:0] ex, ez;
    logic signed [15:0] ax [3][3];

    // stage 1
    logic signed [35:0] m_ax_next, m_by_next, m_cz_next, q_x_next, q_z_next;
    logic signed [29:0] dot_next [3];
    logic signed [35:0] m_ax_reg, m_by_reg, m_cz_reg, q_x_reg, q_z_reg;
    logic signed [29:0] dot_reg [3];
    logic               vld1_reg, vis1_reg;
    item_t              item1_reg;

    // stage 2
    logic signed [39:0] s_next, s_reg;
    logic        [36:0] rq_next, rq_reg;
    logic        [53:0] rb_next [3];
    logic        [53:0] rb_reg [3];
    logic               vld2_reg, vis2_reg;
    item_t              item2_reg;
    logic signed [53:0] prod [3];
    logic signed [23:0] ext_s [3];

    // stage 3
    logic signed [59:0] lhs, thr;
    logic               reject;
    logic               vld3_reg, vis3_reg;
    item_t              item3_reg;

    assign a  = plane[11:0];
    assign b  = plane[23:12];
    assign c  = plane[35:24];
    assign d  = plane[63:36];
    assign cx = bus_in.item.center_x;
    assign cy = bus_in.item.center_y;
    assign cz = bus_in.item.center_z;
    assign ex = {1'b0, bus_in.item.extent_x};
    assign ez = {1'b0, bus_in.item.extent_z};

    always_comb
    begin
        ax[0][0] = bus_in.item.axis_first[15:0];
        ax[0][1] = bus_in.item.axis_first[31:16];
        ax[0][2] = bus_in.item.axis_first[47:32];
        ax[1][0] = bus_in.item.axis_second[15:0];
        ax[1][1] = bus_in.item.axis_second[31:16];
        ax[1][2] = bus_in.item.axis_second[47:32];
        ax[2][0] = bus_in.item.axis_third[15:0];
        ax[2][1] = bus_in.item.axis_third[31:16];
        ax[2][2] = bus_in.item.axis_third[47:32];
        m_ax_next = a * cx;
        m_by_next = b * cy;
        m_cz_next = c * cz;
        q_x_next  = a * ex;
        q_z_next  = c * ez;
        for (int k = 0; k < 3; k++)
        begin
            dot_next[k] = 30'(a * ax[k][0]) + 30'(b * ax[k][1]) + 30'(c * ax[k][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= bus_in.vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_ax_reg  <= m_ax_next;
            m_by_reg  <= m_by_next;
            m_cz_reg  <= m_cz_next;
            q_x_reg   <= q_x_next;
            q_z_reg   <= q_z_next;
            dot_reg   <= dot_next;
            vis1_reg  <= bus_in.vis;
            item1_reg <= bus_in.item;
            s_reg     <= s_next;
            rq_reg    <= rq_next;
            rb_reg    <= rb_next;
            vis2_reg  <= vis1_reg;
            item2_reg <= item1_reg;
            vis3_reg  <= vis2_reg & ~reject;
            item3_reg <= item2_reg;
        end
    end

    always_comb
    begin
        ext_s[0] = {1'b0, item1_reg.extent_x};
        ext_s[1] = {1'b0, item1_reg.extent_y};
        ext_s[2] = {1'b0, item1_reg.extent_z};
        // quad ignores the y term
        if (item1_reg.command == CMD_QUAD)
        begin
            s_next = 40'(m_ax_reg) + 40'(m_cz_reg) + 40'($signed({d, 10'b0}));
        end
        else
        begin
            s_next = 40'(m_ax_reg) + 40'(m_by_reg) + 40'(m_cz_reg)
                   + 40'($signed({d, 10'b0}));
        end
        rq_next = 37'(q_x_reg[35] ? -q_x_reg : q_x_reg)
                + 37'(q_z_reg[35] ? -q_z_reg : q_z_reg);
        for (int k = 0; k < 3; k++)
        begin
            prod[k]    = dot_reg[k] * ext_s[k];
            rb_next[k] = prod[k][53] ? 54'(-prod[k]) : 54'(prod[k]);
        end
    end

    always_comb
    begin
        unique case (cmd_t'(item2_reg.command))
            CMD_POINT:
            begin
                lhs = 60'(s_reg);
                thr = '0;
            end
            CMD_SPHERE:
            begin
                lhs = 60'(s_reg);
                thr = -$signed(60'({item2_reg.radius, 10'b0}));
            end
            CMD_QUAD:
            begin
                lhs = 60'(s_reg);
                thr = -$signed(60'(rq_reg));
            end
            default:
            begin
                lhs = $signed({s_reg, 14'b0});
                thr = -$signed(60'(rb_reg[0]) + 60'(rb_reg[1]) + 60'(rb_reg[2]));
            end
        endcase
        reject = (lhs <= thr);
    end

    assign bus_out.vld  = vld3_reg;
    assign bus_out.vis  = vis3_reg;
    assign bus_out.item = item3_reg;
endmodule

// ===== design/frustum_cull_test.sv =====
// top level: apb plane registers and a chain of six plane cells
// depends on fct_pkg, fct_if, fct_apb_regs, fct_cell
//
// channel  dir  protocol     contents
// prim     in   valid/ready  command, center, extents, radius, axes
// result   out  valid/ready  visible
// apb      in   apb write    six planes, 64 bits, at 8*i
//
// one beat per cycle sustained while the chain is not held;
// the whole chain holds while a result waits and ready is low
// rst_n clears valids and planes
module frustum_cull_test (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fct_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fct_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fct_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    fct_prim_if.sink                       prim,
    fct_result_if.source                   result
);
    import fct_pkg::*;

    logic [PLANE_COUNT-1:0][63:0] planes;
    cell_bus_t                    chain [PLANE_COUNT+1];
    logic                         en;

    fct_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    assign en         = !chain[PLANE_COUNT].vld || result.ready;
    assign prim.ready = en;

    always_comb
    begin
        chain[0].vld              = prim.valid;
        chain[0].vis              = 1'b1;
        chain[0].item.command     = prim.command;
        chain[0].item.center_x    = prim.center_x;
        chain[0].item.center_y    = prim.center_y;
        chain[0].item.center_z    = prim.center_z;
        chain[0].item.extent_x    = prim.extent_x;
        chain[0].item.extent_y    = prim.extent_y;
        chain[0].item.extent_z    = prim.extent_z;
        chain[0].item.radius      = prim.radius;
        chain[0].item.axis_first  = prim.axis_first;
        chain[0].item.axis_second = prim.axis_second;
        chain[0].item.axis_third  = prim.axis_third;
    end

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_cell
        fct_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .plane   (planes[p]),
            .bus_in  (chain[p]),
            .bus_out (chain[p+1])
        );
    end

    assign result.valid   = chain[PLANE_COUNT].vld;
    assign result.visible = chain[PLANE_COUNT].vis;
endmodule
